// ===== src/pgfa_pkg.sv =====
// pgfa_pkg: shared types and codes for the partition gap-fit allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pgfa_pkg;
    localparam int AW = 31;
    localparam int HW = 16;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_NO_SPACE = 3'd2;
    localparam logic [2:0] ST_EXT      = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic [1:0] REG_DISK   = 2'd0;
    localparam logic [1:0] REG_HEADER = 2'd1;
    localparam logic [1:0] REG_FIT    = 2'd2;

    typedef struct packed {
        logic load;
        logic commit;
    } ctl_t;

    typedef struct packed {
        logic [2:0]    status;
        logic [AW-1:0] start;
        logic [1:0]    slot;
    } res_t;
endpackage
`default_nettype wire

// ===== src/pgfa_ctrl.sv =====
// pgfa_ctrl: handshake controller for the allocator
// depends on pgfa_pkg
`timescale 1ns / 1ps
`default_nettype none
module pgfa_ctrl
    import pgfa_pkg::*;
(
    input  wire  clk,
    input  wire  rst_n,
    input  wire  s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  wire  m_tready,
    output ctl_t ctl
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl.load = 1'b0;
        ctl.commit = 1'b0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctl.load = 1'b1;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                ctl.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

// ===== src/pgfa_dp.sv =====
// pgfa_dp: partition table, gap formation and fit selection
// depends on pgfa_pkg
`timescale 1ns / 1ps
`default_nettype none
module pgfa_dp
    import pgfa_pkg::*;
#(
    parameter int SLOTS = 4
)
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire  ctl_t      ctl,
    input  wire  [34:0]     in_data,
    input  wire             cfg_we,
    input  wire  [1:0]      cfg_index,
    input  wire  [AW-1:0]   cfg_data,
    output res_t            res
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NG = SLOTS + 1;

    logic [AW-1:0] disk_reg;
    logic [HW-1:0] hdr_reg;
    logic [1:0]    fit_reg;
    logic [AW-1:0] est_reg [SLOTS];
    logic [AW-1:0] esz_reg [SLOTS];
    logic [SLOTS-1:0] eext_reg;
    logic [34:0]   in_reg;
    res_t          res_reg;

    logic          op;
    logic [AW-1:0] req;
    logic          wext;
    logic [1:0]    sel;
    logic [SW-1:0] sel_idx;
    assign op   = in_reg[0];
    assign req  = in_reg[31:1];
    assign wext = in_reg[32];
    assign sel  = in_reg[34:33];
    assign sel_idx = SW'(sel);

    logic [SLOTS-1:0] live;
    logic [SW-1:0]    rank [SLOTS];
    logic [SW-1:0]    ord [SLOTS];
    logic [SLOTS-1:0] has_ord;
    logic [AW:0]      gs [NG];
    logic [AW:0]      gl [NG];
    logic [NG-1:0]    gv;
    logic             ext_hit, have_free, found;
    logic [SW-1:0]    free_slot;
    logic [AW:0]      pick_len, pick_start, endv, prev_end;
    res_t             res_next;
    logic             do_write, do_release;

    always_comb
    begin
        ext_hit = 1'b0;
        have_free = 1'b0;
        free_slot = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            live[i] = (esz_reg[i] != '0);
            if (live[i])
            begin
                if (eext_reg[i])
                begin
                    ext_hit = 1'b1;
                end
            end
            else if (!have_free)
            begin
                have_free = 1'b1;
                free_slot = SW'(i);
            end
        end
        // rank of each live entry among live entries by start then slot
        for (int i = 0; i < SLOTS; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < SLOTS; j++)
            begin
                if (live[j] && j != i && ((est_reg[j] < est_reg[i]) ||
                    (est_reg[j] == est_reg[i] && j < i)))
                begin
                    rank[i] = rank[i] + 1'b1;
                end
            end
        end
        for (int k = 0; k < SLOTS; k++)
        begin
            ord[k] = '0;
            has_ord[k] = 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (live[i] && rank[i] == SW'(k))
                begin
                    ord[k] = SW'(i);
                    has_ord[k] = 1'b1;
                end
            end
        end
        // gap k is the gap before sorted entry k; gap NG-1 runs from the last entry to the disk end
        prev_end = {1'b0, {(AW-HW){1'b0}}, hdr_reg};
        endv = prev_end;
        for (int k = 0; k < NG; k++)
        begin
            gs[k] = prev_end;
            gl[k] = '0;
            gv[k] = 1'b0;
        end
        for (int k = 0; k < SLOTS; k++)
        begin
            if (has_ord[k])
            begin
                gs[k] = prev_end;
                gv[k] = {1'b0, est_reg[ord[k]]} > prev_end;
                gl[k] = {1'b0, est_reg[ord[k]]} - prev_end;
                prev_end = {1'b0, est_reg[ord[k]]} + {1'b0, esz_reg[ord[k]]};
            end
        end
        endv = prev_end;
        gs[NG-1] = endv;
        gv[NG-1] = {1'b0, disk_reg} > endv;
        gl[NG-1] = {1'b0, disk_reg} - endv;

        found = 1'b0;
        pick_len = '0;
        pick_start = '0;
        for (int k = 0; k < NG; k++)
        begin
            if (gv[k] && gl[k] >= {1'b0, req} && req != '0)
            begin
                case (fit_reg)
                    FIT_FIRST:
                    begin
                        if (!found)
                        begin
                            found = 1'b1;
                            pick_start = gs[k];
                        end
                    end
                    FIT_BEST:
                    begin
                        if (!found || gl[k] < pick_len)
                        begin
                            found = 1'b1;
                            pick_len = gl[k];
                            pick_start = gs[k];
                        end
                    end
                    FIT_WORST:
                    begin
                        if (!found || gl[k] > pick_len)
                        begin
                            found = 1'b1;
                            pick_len = gl[k];
                            pick_start = gs[k];
                        end
                    end
                    default: ;
                endcase
            end
        end

        do_write = 1'b0;
        do_release = 1'b0;
        res_next.status = ST_OK;
        res_next.start = '0;
        res_next.slot = '0;
        if (op)
        begin
            res_next.slot = sel;
            if ({30'd0, sel} >= SLOTS || !live[sel_idx])
            begin
                res_next.status = ST_EMPTY;
            end
            else
            begin
                do_release = 1'b1;
            end
        end
        else if (wext && ext_hit)
        begin
            res_next.status = ST_EXT;
        end
        else if (!have_free)
        begin
            res_next.status = ST_FULL;
        end
        else if (!found)
        begin
            res_next.status = ST_NO_SPACE;
        end
        else
        begin
            do_write = 1'b1;
            res_next.start = pick_start[AW-1:0];
            res_next.slot = 2'(free_slot);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_reg <= AW'(1048576);
            hdr_reg  <= HW'(128);
            fit_reg  <= FIT_FIRST;
            eext_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                est_reg[i] <= '0;
                esz_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DISK:   disk_reg <= cfg_data;
                    REG_HEADER: hdr_reg <= cfg_data[HW-1:0];
                    REG_FIT:    fit_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end
            if (ctl.commit && do_write)
            begin
                est_reg[free_slot]  <= pick_start[AW-1:0];
                esz_reg[free_slot]  <= req;
                eext_reg[free_slot] <= wext;
            end
            if (ctl.commit && do_release)
            begin
                est_reg[sel_idx]  <= '0;
                esz_reg[sel_idx]  <= '0;
                eext_reg[sel_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            in_reg <= in_data;
        end
        if (ctl.commit)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;
endmodule
`default_nettype wire

// ===== src/partition_gap_fit_allocator.sv =====
// partition_gap_fit_allocator: top level joining controller and datapath
// depends on pgfa_pkg, pgfa_ctrl, pgfa_dp
`timescale 1ns / 1ps
`default_nettype none
// usage:
//   s_tdata carries one request; m_tdata returns exactly one result per request.
//   a request is taken when s_tvalid and s_tready are high at a clock edge.
//   each request passes through three states: capture, table update, result hold.
//   one request is in flight at a time, so a new request is taken only after
//   the previous result has been accepted; the three-state controller sets this.
//   while m_tvalid is high and m_tready low the result holds and s_tready
//   stays low.
//   cfg_we writes register cfg_index (0 disk size, 1 header bytes, 2 fit mode)
//   at any edge; write only while idle.
//   reset clears the table (all slots empty) and loads disk size 1048576,
//   header 128 bytes and first fit.
module partition_gap_fit_allocator
    import pgfa_pkg::*;
#(
    parameter int SLOTS = 4
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // op, req_size, want_extended, slot_sel, zeros
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // status, alloc_start, alloc_slot, zeros
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_index,
    input  wire  [30:0] cfg_data
);
    ctl_t ctl;
    res_t res;

    pgfa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .ctl(ctl)
    );

    pgfa_dp #(.SLOTS(SLOTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl),
        .in_data(s_tdata[34:0]),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .res(res)
    );

    assign m_tdata = {4'd0, res.slot, res.start, res.status};
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// tb: self-checking testbench for partition_gap_fit_allocator
// predicts each result with an internal table model and compares field by field
// depends on pgfa_pkg and partition_gap_fit_allocator
`timescale 1ns / 1ps
module tb;
    import pgfa_pkg::*;

    localparam int NSLOT = 4;
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [30:0] cfg_data;

    partition_gap_fit_allocator #(.SLOTS(NSLOT)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // partition table mirror
    logic [30:0] tbl_start [NSLOT];
    logic [30:0] tbl_size [NSLOT];
    logic        tbl_ext [NSLOT];
    logic [30:0] disk_size;
    logic [15:0] header_bytes;
    logic [1:0]  fit_mode;

    res_t expected_results[$];
    int   errors;
    int   send_idle_pct;
    int   recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("partition_gap_fit_allocator verification failed");
        $finish;
    end

    function automatic res_t predict_allocation(logic op, logic [30:0] req,
                                                logic want_ext, logic [1:0] sel);
        res_t r;
        int order[NSLOT];
        logic [32:0] gs[NSLOT+1];
        logic [32:0] gl[NSLOT+1];
        logic [32:0] a;
        logic [32:0] b;
        int n;
        int ng;
        int j;
        int free_slot;
        int pick;
        r = '0;
        n = 0;
        ng = 0;
        free_slot = -1;
        pick = -1;
        if (op == OP_FREE)
        begin
            r.slot = sel;
            if (tbl_size[sel] == 0)
            begin
                r.status = ST_EMPTY;
                return r;
            end
            tbl_start[sel] = '0;
            tbl_size[sel] = '0;
            tbl_ext[sel] = 1'b0;
            r.status = ST_OK;
            return r;
        end
        if (want_ext)
            for (int i = 0; i < NSLOT; i++)
                if (tbl_size[i] != 0 && tbl_ext[i])
                begin
                    r.status = ST_EXT;
                    return r;
                end
        for (int i = 0; i < NSLOT; i++)
        begin
            if (tbl_size[i] == 0)
            begin
                if (free_slot < 0)
                    free_slot = i;
            end
            else
            begin
                j = n;
                while (j > 0 && tbl_start[order[j-1]] > tbl_start[i])
                begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = i;
                n++;
            end
        end
        if (free_slot < 0)
        begin
            r.status = ST_FULL;
            return r;
        end
        // gaps: header to first, between neighbours, last to disk end
        a = {17'd0, header_bytes};
        for (int i = 0; i <= n; i++)
        begin
            b = (i < n) ? {2'b0, tbl_start[order[i]]} : {2'b0, disk_size};
            if (b > a)
            begin
                gs[ng] = a;
                gl[ng] = b - a;
                ng++;
            end
            if (i < n)
                a = {2'b0, tbl_start[order[i]]} + {2'b0, tbl_size[order[i]]};
        end
        if (req != 0)
            for (int i = 0; i < ng; i++)
            begin
                if (gl[i] < req)
                    continue;
                if (fit_mode == FIT_FIRST)
                begin
                    pick = i;
                    break;
                end
                else if (fit_mode == FIT_BEST)
                begin
                    if (pick < 0 || gl[i] < gl[pick])
                        pick = i;
                end
                else if (fit_mode == FIT_WORST)
                begin
                    if (pick < 0 || gl[i] > gl[pick])
                        pick = i;
                end
            end
        if (pick < 0)
        begin
            r.status = ST_NO_SPACE;
            return r;
        end
        tbl_start[free_slot] = gs[pick][30:0];
        tbl_size[free_slot] = req;
        tbl_ext[free_slot] = want_ext;
        r.status = ST_OK;
        r.start = gs[pick][30:0];
        r.slot = free_slot[1:0];
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        res_t got;
        res_t exp_r;
        if (rst_n)
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = m_tdata[2:0];
            got.start = m_tdata[33:3];
            got.slot = m_tdata[35:34];
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got.status !== exp_r.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_r.status, got.status);
                    errors++;
                end
                if (got.start !== exp_r.start)
                begin
                    $display("%0t: alloc_start expected %0d actual %0d", $time,
                             exp_r.start, got.start);
                    errors++;
                end
                if (got.slot !== exp_r.slot)
                begin
                    $display("%0t: alloc_slot expected %0d actual %0d", $time,
                             exp_r.slot, got.slot);
                    errors++;
                end
            end
        end
    end

    task automatic send_request(logic op, logic [30:0] req, logic want_ext,
                                logic [1:0] sel);
        res_t exp_item;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, sel, want_ext, req, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        exp_item = predict_allocation(op, req, want_ext, sel);
        expected_results = {expected_results, exp_item};
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_DISK)
            disk_size = val;
        else if (idx == REG_HEADER)
            header_bytes = val[15:0];
        else
            fit_mode = val[1:0];
    endtask

    task automatic free_all();
        for (int i = 0; i < NSLOT; i++)
            send_request(OP_FREE, '0, 1'b0, i[1:0]);
    endtask

    task automatic test_directed();
        send_request(OP_FREE, '0, 1'b0, 2'd3);
        send_request(OP_ALLOC, '0, 1'b0, 2'd0);
        send_request(OP_ALLOC, 31'd1000, 1'b1, 2'd0);
        send_request(OP_ALLOC, 31'd500, 1'b1, 2'd0);
        send_request(OP_ALLOC, 31'd2000, 1'b0, 2'd3);
        send_request(OP_ALLOC, 31'd1, 1'b0, 2'd0);
        send_request(OP_ALLOC, 31'd1, 1'b0, 2'd0);
        send_request(OP_FREE, '0, 1'b0, 2'd1);
        send_request(OP_FREE, '0, 1'b0, 2'd1);
        send_request(OP_ALLOC, 31'h7fffffff, 1'b0, 2'd0);
        send_request(OP_ALLOC, 31'd1048448, 1'b0, 2'd0);
        free_all();
    endtask

    task automatic test_fit_modes();
        for (int m = 0; m < 4; m++)
        begin
            write_reg(REG_FIT, 31'(m));
            // holes of different sizes, then a fitting request
            send_request(OP_ALLOC, 31'd100, 1'b0, 2'd0);
            send_request(OP_ALLOC, 31'd300, 1'b0, 2'd0);
            send_request(OP_ALLOC, 31'd200, 1'b0, 2'd0);
            send_request(OP_ALLOC, 31'd50, 1'b0, 2'd0);
            send_request(OP_FREE, '0, 1'b0, 2'd0);
            send_request(OP_FREE, '0, 1'b0, 2'd2);
            send_request(OP_ALLOC, 31'd90, 1'b1, 2'd0);
            free_all();
        end
    endtask

    task automatic test_disk_extremes();
        write_reg(REG_DISK, 31'h7fffffff);
        write_reg(REG_HEADER, 31'hffff);
        send_request(OP_ALLOC, 31'h7fff0000, 1'b0, 2'd0);
        send_request(OP_ALLOC, 31'd1, 1'b0, 2'd0);
        free_all();
        write_reg(REG_DISK, 31'd100);
        write_reg(REG_HEADER, 31'd100);
        send_request(OP_ALLOC, 31'd1, 1'b0, 2'd0);
        write_reg(REG_DISK, 31'd0);
        write_reg(REG_HEADER, 31'd0);
        send_request(OP_ALLOC, 31'd1, 1'b0, 2'd0);
    endtask

    task automatic test_random(int count);
        logic [30:0] req;
        for (int k = 0; k < count; k++)
        begin
            if (k % 60 == 0)
            begin
                wait_idle();
                write_reg(REG_DISK, ($urandom_range(3) == 0) ? 31'($urandom())
                                                             : 31'($urandom_range(4096, 1)));
                write_reg(REG_HEADER, ($urandom_range(4) == 0) ? 31'($urandom())
                                                               : 31'($urandom_range(64)));
                write_reg(REG_FIT, 31'($urandom_range(3)));
            end
            case ($urandom_range(9))
                0: req = 31'($urandom());
                1: req = '0;
                default: req = 31'($urandom_range(1200, 1));
            endcase
            if ($urandom_range(2) == 0)
                send_request(OP_FREE, '0, 1'b0, 2'($urandom_range(3)));
            else
                send_request(OP_ALLOC, req, $urandom_range(3) == 0,
                             2'($urandom_range(3)));
        end
    endtask

    initial
    begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        send_idle_pct = 16;
        recv_idle_pct = 60;
        for (int i = 0; i < NSLOT; i++)
        begin
            tbl_start[i] = '0;
            tbl_size[i] = '0;
            tbl_ext[i] = 1'b0;
        end
        disk_size = 31'd1048576;
        header_bytes = 16'd128;
        fit_mode = FIT_FIRST;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fit_modes();
        test_disk_extremes();
        test_random(160);
        send_idle_pct = 60;
        recv_idle_pct = 16;
        test_random(160);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(160);
        wait_idle();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("partition_gap_fit_allocator verification clean");
        else
            $display("partition_gap_fit_allocator verification failed");
        $finish;
    end
endmodule

// ===== files.f =====
src/pgfa_pkg.sv
src/pgfa_ctrl.sv
src/pgfa_dp.sv
src/partition_gap_fit_allocator.sv
test/tb.sv
